// ----- rtl/core/bfsa_pkg.sv -----
`default_nettype none
package bfsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ADDR_BITS_DEF    = 20;
    localparam int OWNER_BITS_DEF   = 8;

    localparam int SIZE_W = 21;
    localparam int BASE_W = 20;
    localparam int OWN_W  = 8;

    localparam logic [SIZE_W-1:0] MEMSIZE_RESET = 21'h100000;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_HOLE   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_STRATEGY  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_ZERO      = 3'd5;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [OWN_W-1:0]  owner_id;
        logic [SIZE_W-1:0] request_size;
        logic              use_best_fit;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [BASE_W-1:0] base_address;
    } t_rsp;

endpackage
`default_nettype wire

// ----- rtl/core/bfsa_mem.sv -----
`default_nettype none
module bfsa_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 49
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/bfsa_ctrl.sv -----
`default_nettype none
module bfsa_ctrl #(
    parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = bfsa_pkg::ADDR_BITS_DEF,
    parameter int OWNER_BITS   = bfsa_pkg::OWNER_BITS_DEF,
    localparam int IW = $clog2(MAX_SEGMENTS),
    localparam int EW = 2 * ADDR_BITS + OWNER_BITS + 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire bfsa_pkg::t_req          i_req,
    output logic                         o_valid,
    output bfsa_pkg::t_rsp               o_rsp,
    input  wire                          i_cfg_we,
    input  wire [bfsa_pkg::SIZE_W-1:0]   i_cfg_wdata,
    output logic                         o_mem_we,
    output logic [IW-1:0]                o_mem_waddr,
    output logic [EW-1:0]                o_mem_wdata,
    output logic [IW-1:0]                o_mem_raddr,
    input  wire [EW-1:0]                 i_mem_rdata
);

    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int MW  = (ADDR_BITS + 1 > bfsa_pkg::SIZE_W) ? ADDR_BITS + 1 : bfsa_pkg::SIZE_W;
    localparam int AB  = ADDR_BITS;
    localparam int OB  = OWNER_BITS;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_SPLIT  = 3'd4;
    localparam logic [2:0] S_SPLIT2 = 3'd5;
    localparam logic [2:0] S_REL    = 3'd6;

    logic [2:0]                  r_state, n_state;
    logic [bfsa_pkg::SIZE_W-1:0] r_msize, n_msize;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_i, n_i;
    logic [CW-1:0]               r_w, n_w;
    logic                        r_rv, n_rv;
    logic [IW-1:0]               r_ri, n_ri;
    logic [OB-1:0]               r_own, n_own;
    logic [bfsa_pkg::SIZE_W-1:0] r_size, n_size;
    logic                        r_found, n_found;
    logic [MW-1:0]               r_best, n_best;
    logic [AB-1:0]               r_blow, n_blow;
    logic [AB-1:0]               r_bhigh, n_bhigh;
    logic [IW-1:0]               r_pick, n_pick;
    logic [EW-1:0]               r_acc, n_acc;
    logic                        r_accv, n_accv;
    logic                        r_valid, n_valid;
    bfsa_pkg::t_rsp              r_rsp, n_rsp;

    logic [AB-1:0] e_low, e_high;
    logic [OB-1:0] e_own;
    logic          e_used, e_used_n, e_match, acc_used;
    logic [MW-1:0] e_hole, size_ext, ms_ext, cap_ext, lo_plus;
    logic [AB-1:0] init_high;

    assign e_low    = i_mem_rdata[EW-1 -: AB];
    assign e_high   = i_mem_rdata[EW-AB-1 -: AB];
    assign e_own    = i_mem_rdata[OB:1];
    assign e_used   = i_mem_rdata[0];
    assign e_match  = e_used && (e_own == r_own);
    assign e_used_n = e_used && !e_match;
    assign acc_used = r_acc[0];
    assign e_hole   = MW'(e_high) - MW'(e_low) + MW'(1);
    assign size_ext = MW'(r_size);
    assign ms_ext   = MW'(r_msize);
    assign cap_ext  = MW'(1) << AB;
    assign lo_plus  = MW'(r_blow) + size_ext;

    always_comb begin
        priority if (ms_ext == '0) begin
            init_high = '0;
        end else if (ms_ext > cap_ext) begin
            init_high = '1;
        end else begin
            init_high = AB'(ms_ext - MW'(1));
        end
    end

    always_comb begin
        n_state = r_state;
        n_msize = r_msize;
        n_count = r_count;
        n_i     = r_i;
        n_w     = r_w;
        n_rv    = 1'b0;
        n_ri    = r_ri;
        n_own   = r_own;
        n_size  = r_size;
        n_found = r_found;
        n_best  = r_best;
        n_blow  = r_blow;
        n_bhigh = r_bhigh;
        n_pick  = r_pick;
        n_acc   = r_acc;
        n_accv  = r_accv;
        n_valid = 1'b0;
        n_rsp   = r_rsp;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = r_i[IW-1:0];

        unique case (r_state)
            S_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = {AB'(0), init_high, OB'(0), 1'b0};
                n_count     = CW'(1);
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_own   = OB'(i_req.owner_id);
                    n_size  = i_req.request_size;
                    n_i     = '0;
                    n_w     = '0;
                    n_found = 1'b0;
                    n_accv  = 1'b0;
                    n_best  = '1;
                    if (i_req.action == bfsa_pkg::ACT_RELEASE) begin
                        n_state = S_REL;
                    end else if (!i_req.use_best_fit) begin
                        n_valid = 1'b1;
                        n_rsp   = '{status: bfsa_pkg::ST_STRATEGY, base_address: '0};
                    end else if (i_req.request_size == '0) begin
                        n_valid = 1'b1;
                        n_rsp   = '{status: bfsa_pkg::ST_ZERO, base_address: '0};
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_i < r_count) begin
                    n_rv = 1'b1;
                    n_ri = r_i[IW-1:0];
                    n_i  = r_i + CW'(1);
                end
                if (r_rv) begin
                    if (!e_used && e_hole >= size_ext && e_hole < r_best) begin
                        n_best  = e_hole;
                        n_blow  = e_low;
                        n_bhigh = e_high;
                        n_pick  = r_ri;
                        n_found = 1'b1;
                    end
                end else if (r_i == r_count) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    priority if (!r_found) begin
                        n_rsp = '{status: bfsa_pkg::ST_NO_HOLE, base_address: '0};
                    end else if (r_best == size_ext) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_pick;
                        o_mem_wdata = {r_blow, r_bhigh, r_own, 1'b1};
                        n_rsp = '{status: bfsa_pkg::ST_OK,
                                  base_address: bfsa_pkg::BASE_W'(r_blow)};
                    end else if (r_count == CNT_MAX) begin
                        n_rsp = '{status: bfsa_pkg::ST_FULL, base_address: '0};
                    end else begin
                        n_valid = 1'b0;
                        n_i     = r_count - CW'(1);
                        n_state = (CW'(r_pick) + CW'(1) == r_count) ? S_SPLIT : S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (r_i > CW'(r_pick)) begin
                    n_rv = 1'b1;
                    n_ri = r_i[IW-1:0];
                    n_i  = r_i - CW'(1);
                end
                if (r_rv) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_ri + IW'(1);
                    o_mem_wdata = i_mem_rdata;
                end else if (r_i == CW'(r_pick)) begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pick + IW'(1);
                o_mem_wdata = {AB'(lo_plus), r_bhigh, OB'(0), 1'b0};
                n_state     = S_SPLIT2;
            end
            S_SPLIT2: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pick;
                o_mem_wdata = {r_blow, AB'(lo_plus - MW'(1)), r_own, 1'b1};
                n_count     = r_count + CW'(1);
                n_valid     = 1'b1;
                n_rsp       = '{status: bfsa_pkg::ST_OK,
                                base_address: bfsa_pkg::BASE_W'(r_blow)};
                n_state     = S_IDLE;
            end
            S_REL: begin
                if (r_i < r_count) begin
                    n_rv = 1'b1;
                    n_ri = r_i[IW-1:0];
                    n_i  = r_i + CW'(1);
                end
                if (r_rv) begin
                    if (e_match) begin
                        n_found = 1'b1;
                    end
                    if (r_accv && !e_used_n && !acc_used) begin
                        n_acc = {r_acc[EW-1 -: AB], e_high, r_acc[OB:0]};
                    end else begin
                        if (r_accv) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_w[IW-1:0];
                            o_mem_wdata = r_acc;
                            n_w         = r_w + CW'(1);
                        end
                        n_acc  = {i_mem_rdata[EW-1:1], e_used_n};
                        n_accv = 1'b1;
                    end
                end else if (r_i == r_count) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_w[IW-1:0];
                    o_mem_wdata = r_acc;
                    n_count     = r_w + CW'(1);
                    n_valid     = 1'b1;
                    n_rsp       = '{status: r_found ? bfsa_pkg::ST_OK : bfsa_pkg::ST_NOT_FOUND,
                                    base_address: '0};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        if (i_cfg_we) begin
            n_msize = i_cfg_wdata;
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_msize <= bfsa_pkg::MEMSIZE_RESET;
            r_count <= CW'(1);
            r_rv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_msize <= n_msize;
            r_count <= n_count;
            r_rv    <= n_rv;
            r_valid <= n_valid;
        end
        r_i     <= n_i;
        r_w     <= n_w;
        r_ri    <= n_ri;
        r_own   <= n_own;
        r_size  <= n_size;
        r_found <= n_found;
        r_best  <= n_best;
        r_blow  <= n_blow;
        r_bhigh <= n_bhigh;
        r_pick  <= n_pick;
        r_acc   <= n_acc;
        r_accv  <= n_accv;
        r_rsp   <= n_rsp;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> (r_count >= CW'(1) && r_count <= CNT_MAX))
        else $error("segment count out of range");

    a_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (CW'(o_mem_waddr) <= r_count))
        else $error("table write beyond used entries");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE || r_state == S_INIT))
        else $error("result shown while busy");

    a_err_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != bfsa_pkg::ST_OK) |-> (o_rsp.base_address == '0))
        else $error("nonzero base with error status");

endmodule
`default_nettype wire

// ----- rtl/core/best_fit_segment_allocator_unit.sv -----
// Rejected requests are answered from idle; requests and releases scan all live segments,
// and a request that splits a hole may also shift the table entries above it.
// Throughput: one item at a time, bounded by the one-read-per-cycle segment table scan.
// Reset: synchronous; table rebuilt to one free segment in state S_INIT, busy meanwhile.
// A config write rebuilds the table the same way. Results cannot be stalled.
`default_nettype none
module best_fit_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = bfsa_pkg::ADDR_BITS_DEF,
    parameter int OWNER_BITS   = bfsa_pkg::OWNER_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire bfsa_pkg::t_req         i_req,
    output logic                        o_valid,
    output bfsa_pkg::t_rsp              o_rsp,
    input  wire                         i_cfg_we,
    input  wire [bfsa_pkg::SIZE_W-1:0]  i_cfg_wdata
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int EW = 2 * ADDR_BITS + OWNER_BITS + 1;

    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    bfsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS),
        .OWNER_BITS   (OWNER_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    bfsa_mem #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire
